>>> rtl/qau_pkg.sv
// Shared types, codes and helpers for the quaternion arithmetic unit.
`default_nettype none
package qau_pkg;

	localparam logic [2:0] CMD_MUL  = 3'd0;
	localparam logic [2:0] CMD_ADD  = 3'd1;
	localparam logic [2:0] CMD_SUB  = 3'd2;
	localparam logic [2:0] CMD_CONJ = 3'd3;
	localparam logic [2:0] CMD_INV  = 3'd4;
	localparam logic [2:0] CMD_DIV  = 3'd5;

	// quotient bits produced by the restoring divider, one per stage
	localparam int DIV_STEPS = 33;

	localparam int FIFO_AW    = 1;
	localparam int FIFO_DEPTH = 2 ** FIFO_AW;

	typedef enum logic [2:0] {
		OP_MUL  = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_CONJ = 3'd3,
		OP_INV  = 3'd4,
		OP_DIV  = 3'd5,
		OP_NONE = 3'd6
	} op_t;

	// element 0 is the scalar part, then i, j, k
	typedef logic [3:0][31:0] quat_t;

	typedef struct packed {
		op_t   op;
		quat_t p;
		quat_t q;
	} item_t;

	typedef struct packed {
		op_t         op;
		quat_t       p;
		quat_t       q;
		logic [63:0] n;
		logic        nbig;
		logic        dz;
		logic [3:0]  neg;
		logic [3:0]  azero;
		logic [3:0]  ge;
	} dctl_t;

	// Hamilton product: component c sums p[HAM_PA[c][t]] * b[HAM_QB[c][t]]
	localparam logic [1:0] HAM_PA [4][4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd1, 2'd0, 2'd2, 2'd3},
		'{2'd2, 2'd0, 2'd3, 2'd1},
		'{2'd3, 2'd0, 2'd1, 2'd2}
	};
	localparam logic [1:0] HAM_QB [4][4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd0, 2'd1, 2'd3, 2'd2},
		'{2'd0, 2'd2, 2'd1, 2'd3},
		'{2'd0, 2'd3, 2'd2, 2'd1}
	};
	// bit t set: term t is subtracted
	localparam logic [3:0] HAM_NEG [4] = '{4'b1110, 4'b1000, 4'b1000, 4'b1000};

	// {overflow, value}: clamp to signed 32 bits
	function automatic logic [32:0] sat32(input logic signed [66:0] v);
		if (v[66:31] == '0 || v[66:31] == '1)
			return {1'b0, v[31:0]};
		else if (v[66])
			return {1'b1, 32'h8000_0000};
		else
			return {1'b1, 32'h7FFF_FFFF};
	endfunction

endpackage
`default_nettype wire

>>> rtl/qau_front.sv
// Front end: takes input transactions, decodes the command, registers the item.
`default_nettype none
module qau_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [2:0]          cmd,
	input  wire  signed [31:0]  p_w,
	input  wire  signed [31:0]  p_x,
	input  wire  signed [31:0]  p_y,
	input  wire  signed [31:0]  p_z,
	input  wire  signed [31:0]  q_w,
	input  wire  signed [31:0]  q_x,
	input  wire  signed [31:0]  q_y,
	input  wire  signed [31:0]  q_z,
	output logic                f_valid,
	input  wire                 f_ready,
	output qau_pkg::item_t      f_item
);
	logic           v_q;
	qau_pkg::item_t item_q;
	qau_pkg::op_t   op_dec;
	logic           take;

	always_comb begin
		unique case (cmd)
			qau_pkg::CMD_MUL:  op_dec = qau_pkg::OP_MUL;
			qau_pkg::CMD_ADD:  op_dec = qau_pkg::OP_ADD;
			qau_pkg::CMD_SUB:  op_dec = qau_pkg::OP_SUB;
			qau_pkg::CMD_CONJ: op_dec = qau_pkg::OP_CONJ;
			qau_pkg::CMD_INV:  op_dec = qau_pkg::OP_INV;
			qau_pkg::CMD_DIV:  op_dec = qau_pkg::OP_DIV;
			default:           op_dec = qau_pkg::OP_NONE;
		endcase
	end

	assign in_ready = !v_q || f_ready;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q.op <= op_dec;
			item_q.p  <= {p_z, p_y, p_x, p_w};
			item_q.q  <= {q_z, q_y, q_x, q_w};
		end
	end

	assign f_valid = v_q;
	assign f_item  = item_q;

endmodule
`default_nettype wire

>>> rtl/qau_fifo.sv
// Short queue between the front end and the arithmetic back end.
`default_nettype none
module qau_fifo (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push_valid,
	output logic            push_ready,
	input  qau_pkg::item_t  push_item,
	output logic            pop_valid,
	input  wire             pop_ready,
	output qau_pkg::item_t  pop_item
);
	qau_pkg::item_t                mem_q [qau_pkg::FIFO_DEPTH];
	logic [qau_pkg::FIFO_AW-1:0]   wr_q;
	logic [qau_pkg::FIFO_AW-1:0]   rd_q;
	logic [qau_pkg::FIFO_AW:0]     cnt_q;
	logic                          push;
	logic                          pop;

	assign push_ready = cnt_q != (qau_pkg::FIFO_AW + 1)'(qau_pkg::FIFO_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

endmodule
`default_nettype wire

>>> rtl/qau_back.sv
// Back end: norm, pipelined restoring divider, Hamilton products, rounding and saturation.
`default_nettype none
module qau_back (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  qau_pkg::item_t  item,
	output logic            out_valid,
	input  wire             out_ready,
	output qau_pkg::quat_t  r,
	output logic            ovf,
	output logic            dz
);
	logic adv;

	// stage 1: squares of q
	logic           v_s1;
	qau_pkg::item_t it_s1;
	logic [63:0]    sq_s1 [4];

	// stage 2: squared norm, magnitudes
	logic           v_s2;
	qau_pkg::item_t it_s2;
	logic [63:0]    n_s2;
	logic           nbig_s2;
	logic [31:0]    a_s2 [4];
	logic [3:0]     sgn_s2;
	logic [64:0]    nsum;

	// divider stages; index 0 is loaded from stage 2
	logic           v_d   [qau_pkg::DIV_STEPS+1];
	qau_pkg::dctl_t ctl_d [qau_pkg::DIV_STEPS+1];
	logic [63:0]    rem_d [qau_pkg::DIV_STEPS+1][4];
	logic [32:0]    quo_d [qau_pkg::DIV_STEPS+1][4];

	// stage 4: rounded, signed, saturated inverse
	logic           v_s4;
	qau_pkg::dctl_t ctl_s4;
	qau_pkg::quat_t iq_s4;
	logic           iovf_s4;
	qau_pkg::quat_t iq_c;
	logic           iovf_c;

	// stage 5: the sixteen partial products
	logic                v_s5;
	qau_pkg::dctl_t      ctl_s5;
	qau_pkg::quat_t      iq_s5;
	logic                iovf_s5;
	logic signed [63:0]  pr_s5 [4][4];
	qau_pkg::quat_t      b_op;

	// stage 6: output register
	logic           v_s6;
	qau_pkg::quat_t r_s6;
	logic           ovf_s6;
	logic           dz_s6;
	qau_pkg::quat_t r_c;
	logic           ovf_c;
	logic           dz_c;

	assign adv      = !v_s6 || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_d[0] <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
		end else if (adv) begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_d[0] <= v_s2;
			v_s4   <= v_d[qau_pkg::DIV_STEPS];
			v_s5   <= v_s4;
			v_s6   <= v_s5;
		end
	end

	// stage 1
	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1 <= item;
			for (int i = 0; i < 4; i++)
				sq_s1[i] <= $signed(item.q[i]) * $signed(item.q[i]);
		end
	end

	// stage 2
	assign nsum = 65'(sq_s1[0]) + 65'(sq_s1[1]) + 65'(sq_s1[2]) + 65'(sq_s1[3]);

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s2   <= it_s1;
			n_s2    <= nsum[63:0];
			nbig_s2 <= nsum[64];
			for (int i = 0; i < 4; i++) begin
				a_s2[i]   <= it_s1.q[i][31] ? (~it_s1.q[i] + 32'd1) : it_s1.q[i];
				sgn_s2[i] <= it_s1.q[i][31];
			end
		end
	end

	// divider entry: lane flags and initial remainder
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_d[0].op   <= it_s2.op;
			ctl_d[0].p    <= it_s2.p;
			ctl_d[0].q    <= it_s2.q;
			ctl_d[0].n    <= n_s2;
			ctl_d[0].nbig <= nbig_s2;
			ctl_d[0].dz   <= (n_s2 == '0) && !nbig_s2;
			for (int i = 0; i < 4; i++) begin
				// vector part of the inverse is negated
				ctl_d[0].neg[i]   <= sgn_s2[i] ^ (i != 0);
				ctl_d[0].azero[i] <= a_s2[i] == '0;
				ctl_d[0].ge[i]    <= {32'd0, a_s2[i]} >= n_s2;
				rem_d[0][i]       <= {32'd0, a_s2[i]};
				quo_d[0][i]       <= '0;
			end
		end
	end

	// one quotient bit per stage, all four lanes side by side
	for (genvar k = 0; k < qau_pkg::DIV_STEPS; k++) begin : g_div
		logic [64:0] shl [4];
		logic [3:0]  sub_b;

		always_comb begin
			for (int i = 0; i < 4; i++) begin
				shl[i]   = {rem_d[k][i], 1'b0};
				sub_b[i] = shl[i] >= {1'b0, ctl_d[k].n};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[k+1] <= 1'b0;
			end else if (adv) begin
				v_d[k+1] <= v_d[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ctl_d[k+1] <= ctl_d[k];
				for (int i = 0; i < 4; i++) begin
					rem_d[k+1][i] <= sub_b[i] ? 64'(shl[i] - {1'b0, ctl_d[k].n})
					                          : shl[i][63:0];
					quo_d[k+1][i] <= {quo_d[k][i][31:0], sub_b[i]};
				end
			end
		end
	end

	// stage 4: round half away, pick special cases, apply sign, saturate
	always_comb begin
		logic [33:0] rnd;
		logic [32:0] m;
		iovf_c = 1'b0;
		for (int i = 0; i < 4; i++) begin
			rnd = {1'b0, quo_d[qau_pkg::DIV_STEPS][i]} + 34'd1;
			if (ctl_d[qau_pkg::DIV_STEPS].nbig)
				m = 33'd1;
			else if (ctl_d[qau_pkg::DIV_STEPS].ge[i])
				m = 33'h1_0000_0000;
			else
				m = rnd[33:1];
			if (ctl_d[qau_pkg::DIV_STEPS].azero[i]) begin
				iq_c[i] = '0;
			end else if (ctl_d[qau_pkg::DIV_STEPS].neg[i]) begin
				if (m > 33'h0_8000_0000) begin
					iq_c[i] = 32'h8000_0000;
					iovf_c  = 1'b1;
				end else begin
					iq_c[i] = 32'(33'd0 - m);
				end
			end else begin
				if (m > 33'h0_7FFF_FFFF) begin
					iq_c[i] = 32'h7FFF_FFFF;
					iovf_c  = 1'b1;
				end else begin
					iq_c[i] = m[31:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s4  <= ctl_d[qau_pkg::DIV_STEPS];
			iq_s4   <= iq_c;
			iovf_s4 <= iovf_c;
		end
	end

	// stage 5: divide multiplies by the inverse, everything else by q
	assign b_op = (ctl_s4.op == qau_pkg::OP_DIV) ? iq_s4 : ctl_s4.q;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s5  <= ctl_s4;
			iq_s5   <= iq_s4;
			iovf_s5 <= iovf_s4;
			for (int c = 0; c < 4; c++)
				for (int t = 0; t < 4; t++)
					pr_s5[c][t] <= $signed(ctl_s4.p[qau_pkg::HAM_PA[c][t]])
					             * $signed(b_op[qau_pkg::HAM_QB[c][t]]);
		end
	end

	// stage 6: sums, rounding, simple ops, result select
	always_comb begin
		logic signed [66:0] acc;
		logic [32:0]        st;
		qau_pkg::quat_t     ham_r;
		qau_pkg::quat_t     add_r;
		qau_pkg::quat_t     sub_r;
		qau_pkg::quat_t     conj_r;
		logic               ham_o;
		logic               add_o;
		logic               sub_o;
		logic               conj_o;
		ham_o  = 1'b0;
		add_o  = 1'b0;
		sub_o  = 1'b0;
		conj_o = 1'b0;
		for (int c = 0; c < 4; c++) begin
			acc = '0;
			for (int t = 0; t < 4; t++) begin
				if (qau_pkg::HAM_NEG[c][t])
					acc = acc - 67'(pr_s5[c][t]);
				else
					acc = acc + 67'(pr_s5[c][t]);
			end
			acc      = (acc + 67'sd32768) >>> 16;
			st       = qau_pkg::sat32(acc);
			ham_r[c] = st[31:0];
			ham_o    = ham_o | st[32];

			st       = qau_pkg::sat32(67'($signed(ctl_s5.p[c])) + 67'($signed(ctl_s5.q[c])));
			add_r[c] = st[31:0];
			add_o    = add_o | st[32];

			st       = qau_pkg::sat32(67'($signed(ctl_s5.p[c])) - 67'($signed(ctl_s5.q[c])));
			sub_r[c] = st[31:0];
			sub_o    = sub_o | st[32];

			if (c == 0) begin
				conj_r[c] = ctl_s5.q[c];
			end else begin
				st        = qau_pkg::sat32(67'sd0 - 67'($signed(ctl_s5.q[c])));
				conj_r[c] = st[31:0];
				conj_o    = conj_o | st[32];
			end
		end

		r_c   = '0;
		ovf_c = 1'b0;
		dz_c  = 1'b0;
		case (ctl_s5.op)
			qau_pkg::OP_MUL: begin
				r_c   = ham_r;
				ovf_c = ham_o;
			end
			qau_pkg::OP_ADD: begin
				r_c   = add_r;
				ovf_c = add_o;
			end
			qau_pkg::OP_SUB: begin
				r_c   = sub_r;
				ovf_c = sub_o;
			end
			qau_pkg::OP_CONJ: begin
				r_c   = conj_r;
				ovf_c = conj_o;
			end
			qau_pkg::OP_INV: begin
				if (ctl_s5.dz) begin
					dz_c = 1'b1;
				end else begin
					r_c   = iq_s5;
					ovf_c = iovf_s5;
				end
			end
			qau_pkg::OP_DIV: begin
				if (ctl_s5.dz) begin
					dz_c = 1'b1;
				end else begin
					r_c   = ham_r;
					ovf_c = ham_o | iovf_s5;
				end
			end
			default: begin
				r_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s6   <= r_c;
			ovf_s6 <= ovf_c;
			dz_s6  <= dz_c;
		end
	end

	assign out_valid = v_s6;
	assign r         = r_s6;
	assign ovf       = ovf_s6;
	assign dz        = dz_s6;

endmodule
`default_nettype wire

>>> rtl/quaternion_arithmetic_unit_core.sv
// Top level of the quaternion arithmetic unit.
// Signed Q16.16 quaternion ALU: multiply, add, subtract, conjugate, invert and divide,
// with saturating results, an overflow flag and a divide-by-zero flag. One transaction
// is accepted per cycle and one result leaves per cycle when the output side keeps up.
// A transaction passes through the front register and the queue, then through the 39
// back-end stages. The 33-stage restoring divider that forms the inverse of q makes up
// most of those stages. Every command takes the same path, so results come out in order.
// The queue lets the front end take up to three more transactions while the output
// is stalled.
`default_nettype none
module quaternion_arithmetic_unit_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [2:0]          cmd,
	input  wire  signed [31:0]  p_w,
	input  wire  signed [31:0]  p_x,
	input  wire  signed [31:0]  p_y,
	input  wire  signed [31:0]  p_z,
	input  wire  signed [31:0]  q_w,
	input  wire  signed [31:0]  q_x,
	input  wire  signed [31:0]  q_y,
	input  wire  signed [31:0]  q_z,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic signed [31:0]  r_w,
	output logic signed [31:0]  r_x,
	output logic signed [31:0]  r_y,
	output logic signed [31:0]  r_z,
	output logic                overflow,
	output logic                div_by_zero
);
	logic           f_valid;
	logic           f_ready;
	qau_pkg::item_t f_item;
	logic           b_valid;
	logic           b_ready;
	qau_pkg::item_t b_item;
	qau_pkg::quat_t r;

	qau_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.p_w      (p_w),
		.p_x      (p_x),
		.p_y      (p_y),
		.p_z      (p_z),
		.q_w      (q_w),
		.q_x      (q_x),
		.q_y      (q_y),
		.q_z      (q_z),
		.f_valid  (f_valid),
		.f_ready  (f_ready),
		.f_item   (f_item)
	);

	qau_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_item   (b_item)
	);

	qau_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (b_valid),
		.in_ready  (b_ready),
		.item      (b_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.r         (r),
		.ovf       (overflow),
		.dz        (div_by_zero)
	);

	assign r_w = r[0];
	assign r_x = r[1];
	assign r_y = r[2];
	assign r_z = r[3];

endmodule
`default_nettype wire

>>> rtl/qau_checker.sv
// Port-level checks for the quaternion arithmetic unit, bound to the top level.
`default_nettype none
module qau_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                out_valid,
	input wire                out_ready,
	input wire  signed [31:0] r_w,
	input wire  signed [31:0] r_x,
	input wire  signed [31:0] r_y,
	input wire  signed [31:0] r_z,
	input wire                overflow,
	input wire                div_by_zero
);
	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(r_w) && $stable(r_x)
		&& $stable(r_y) && $stable(r_z) && $stable(overflow) && $stable(div_by_zero))
		else $error("result changed while stalled");

	// zero norm forces a zero result with no overflow
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_by_zero |-> r_w == 0 && r_x == 0 && r_y == 0 && r_z == 0
		&& !overflow)
		else $error("divide by zero result not cleared");

	// nothing reaches the output while reset is held
	a_rst_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid during reset");

	// a result never appears the cycle after reset is released
	a_rst_lat: assert property (@(posedge clk) $rose(arst_n) |=> !out_valid)
		else $error("output valid right after reset");

endmodule

bind quaternion_arithmetic_unit_core qau_checker u_qau_checker (.*);
`default_nettype wire
